// File: design/assert_macros.svh
// assertion macros shared by the torque command frame parser rtl
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define TCFP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent implies consequent in the following cycle
`define TCFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/tcfp_pkg.sv
// shared constants and types of the torque command frame parser
// no dependencies
package tcfp_pkg;

    localparam int MAX_LEN_DEF = 32;
    localparam int FRAME_LEN   = 15;

    localparam logic [15:0] TORQUE_LIMIT_RST = 16'd2000;

    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_T    = 8'd84;
    localparam logic [7:0] CH_L    = 8'd76;
    localparam logic [7:0] CH_R    = 8'd82;
    localparam logic [7:0] CH_M    = 8'd77;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LEN  = 2'd1;
    localparam logic [1:0] ST_BAD_TERM = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] left_torque;
        logic [15:0] right_torque;
        logic [15:0] left_torque_before;
        logic [15:0] right_torque_before;
        logic [7:0]  motion_mode;
        logic [7:0]  motion_mode_before;
        logic [7:0]  side_code;
        logic        left_updated;
        logic        right_updated;
        logic        mode_updated;
    } t_result;

endpackage

// File: design/torque_command_frame_parser.sv
// torque command frame parser top level
// depends on tcfp_pkg, tcfp_cell, tcfp_torque_dec, tcfp_out_buf, assert_macros.svh
//
// usage:
//  - slave stream carries one received character per transaction in i_s_tdata.
//  - a frame is "TLddddTRddddMxy" followed by CR LF; characters are shifted
//    through a row of fifteen byte cells, one cell step per stored character.
//  - master stream carries one result per frame end (good frame, wrong length,
//    bad terminator, overflow); nothing is sent for other characters.
//  - the result is registered in the output buffer when the LF, the bad
//    terminator byte or the overflowing byte is accepted.
//  - throughput: one character per cycle while o_s_tready is high; the decode of both torque fields
//    and the clamp against the limit happen in the cycle of the LF.
//  - a stalled master holds its result; a second result waits in a skid
//    stage, and only then o_s_tready drops.
//  - reset clears the collector, the held torque, mode and side values and
//    sets the torque limit to 2000; the byte cells are not cleared.
//  - i_cfg_we writes the torque limit; write it only while the block is idle.
`include "assert_macros.svh"

module torque_command_frame_parser #(
    parameter int MAX_LEN = tcfp_pkg::MAX_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [15:0] left_torque, [31:16] right_torque, [47:32] left_torque_before,
    // [63:48] right_torque_before, [71:64] motion_mode,
    // [79:72] motion_mode_before, [87:80] side_code
    output logic [87:0] o_m_tdata,
    // [1:0] status, [2] left_updated, [3] right_updated, [4] mode_updated
    output logic [4:0]  o_m_tuser
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int FL    = tcfp_pkg::FRAME_LEN;

    logic             r_cr_pending, n_cr_pending;
    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_limit;
    logic [15:0]      r_left, n_left, r_left_b, n_left_b;
    logic [15:0]      r_right, n_right, r_right_b, n_right_b;
    logic [7:0]       r_mode, n_mode, r_mode_b, n_mode_b, r_side, n_side;

    logic              w_acc;
    logic              w_shift;
    logic              w_push;
    logic [1:0]        w_status;
    logic              w_lu, w_ru, w_mu;
    logic [7:0]        w_cell [FL];
    logic [7:0]        w_left_dig [4];
    logic [7:0]        w_right_dig [4];
    logic [15:0]       w_left_dec, w_right_dec;
    tcfp_pkg::t_result w_res, w_out;

    assign w_acc = i_s_tvalid && o_s_tready;

    // newest character enters the last cell; a full frame has byte 0 in cell 0
    for (genvar k = 0; k < FL; k++) begin : g_cell
        if (k == FL - 1) begin : g_head
            tcfp_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(w_shift),
                .i_byte (i_s_tdata),
                .o_byte (w_cell[k])
            );
        end else begin : g_body
            tcfp_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(w_shift),
                .i_byte (w_cell[k+1]),
                .o_byte (w_cell[k])
            );
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_left_dig[i]  = w_cell[2 + i];
            w_right_dig[i] = w_cell[8 + i];
        end
    end

    tcfp_torque_dec u_left_dec (
        .i_digit (w_left_dig),
        .i_limit (r_limit),
        .o_torque(w_left_dec)
    );

    tcfp_torque_dec u_right_dec (
        .i_digit (w_right_dig),
        .i_limit (r_limit),
        .o_torque(w_right_dec)
    );

    always_comb begin
        n_cr_pending = r_cr_pending;
        n_count      = r_count;
        n_left       = r_left;
        n_left_b     = r_left_b;
        n_right      = r_right;
        n_right_b    = r_right_b;
        n_mode       = r_mode;
        n_mode_b     = r_mode_b;
        n_side       = r_side;
        w_shift      = 1'b0;
        w_push       = 1'b0;
        w_status     = tcfp_pkg::ST_OK;
        w_lu         = 1'b0;
        w_ru         = 1'b0;
        w_mu         = 1'b0;
        if (w_acc) begin
            if (r_cr_pending) begin
                n_cr_pending = 1'b0;
                n_count      = '0;
                w_push       = 1'b1;
                if (i_s_tdata != tcfp_pkg::CH_LF) begin
                    w_status = tcfp_pkg::ST_BAD_TERM;
                end else if (r_count != CNT_W'(FL)) begin
                    w_status = tcfp_pkg::ST_BAD_LEN;
                end else begin
                    w_status = tcfp_pkg::ST_OK;
                    if (w_cell[0] == tcfp_pkg::CH_T && w_cell[1] == tcfp_pkg::CH_L) begin
                        n_left_b = r_left;
                        n_left   = w_left_dec;
                        w_lu     = 1'b1;
                    end
                    if (w_cell[6] == tcfp_pkg::CH_T && w_cell[7] == tcfp_pkg::CH_R) begin
                        n_right_b = r_right;
                        n_right   = w_right_dec;
                        w_ru      = 1'b1;
                    end
                    if (w_cell[12] == tcfp_pkg::CH_M) begin
                        n_mode_b = r_mode;
                        n_mode   = w_cell[13] - tcfp_pkg::CH_ZERO;
                        n_side   = w_cell[14] - tcfp_pkg::CH_ZERO;
                        w_mu     = 1'b1;
                    end
                end
            end else if (i_s_tdata == tcfp_pkg::CH_CR) begin
                n_cr_pending = 1'b1;
            end else if (r_count < CNT_W'(MAX_LEN)) begin
                w_shift = 1'b1;
                n_count = r_count + 1'b1;
            end else begin
                n_count  = '0;
                w_push   = 1'b1;
                w_status = tcfp_pkg::ST_OVERFLOW;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr_pending <= 1'b0;
            r_count      <= '0;
            r_limit      <= tcfp_pkg::TORQUE_LIMIT_RST;
            r_left       <= '0;
            r_left_b     <= '0;
            r_right      <= '0;
            r_right_b    <= '0;
            r_mode       <= '0;
            r_mode_b     <= '0;
            r_side       <= '0;
        end else begin
            r_cr_pending <= n_cr_pending;
            r_count      <= n_count;
            r_left       <= n_left;
            r_left_b     <= n_left_b;
            r_right      <= n_right;
            r_right_b    <= n_right_b;
            r_mode       <= n_mode;
            r_mode_b     <= n_mode_b;
            r_side       <= n_side;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_comb begin
        w_res.status              = w_status;
        w_res.left_torque         = n_left;
        w_res.right_torque        = n_right;
        w_res.left_torque_before  = n_left_b;
        w_res.right_torque_before = n_right_b;
        w_res.motion_mode         = n_mode;
        w_res.motion_mode_before  = n_mode_b;
        w_res.side_code           = n_side;
        w_res.left_updated        = w_lu;
        w_res.right_updated       = w_ru;
        w_res.mode_updated        = w_mu;
    end

    tcfp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_result(w_res),
        .o_ready (o_s_tready),
        .o_valid (o_m_tvalid),
        .i_taken (i_m_tready),
        .o_result(w_out)
    );

    assign o_m_tdata = {w_out.side_code, w_out.motion_mode_before, w_out.motion_mode,
                        w_out.right_torque_before, w_out.left_torque_before,
                        w_out.right_torque, w_out.left_torque};
    assign o_m_tuser = {w_out.mode_updated, w_out.right_updated, w_out.left_updated,
                        w_out.status};

    `TCFP_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(MAX_LEN), "byte count above store size")
    `TCFP_ASSERT_NEXT(a_frame_end_restart, i_clk, i_rst_n, w_acc && r_cr_pending, !r_cr_pending && r_count == '0, "collector did not restart after frame end")
    `TCFP_ASSERT(a_err_no_update, i_clk, i_rst_n, !(w_push && w_status != tcfp_pkg::ST_OK) || !(w_lu || w_ru || w_mu), "error frame flagged an update")

endmodule

// File: design/tcfp_cell.sv
// one byte cell of the frame shift chain
// no dependencies
module tcfp_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    output logic [7:0] o_byte
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// File: design/tcfp_torque_dec.sv
// decodes four weighted characters into a clamped torque in hundredths
// no dependencies beyond tcfp_pkg
module tcfp_torque_dec (
    input  logic [7:0]  i_digit [4],
    input  logic [15:0] i_limit,
    output logic [15:0] o_torque
);

    localparam int SUM_W = 19;

    logic signed [8:0]       w_dig [4];
    logic signed [SUM_W-1:0] w_sum;
    logic signed [SUM_W-1:0] w_limit;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_dig[i] = $signed({1'b0, i_digit[i]}) - $signed({1'b0, tcfp_pkg::CH_ZERO});
        end
    end

    // non-digit characters are weighted all the same
    assign w_sum = SUM_W'(w_dig[0]) * 19'sd1000 + SUM_W'(w_dig[1]) * 19'sd100
                 + SUM_W'(w_dig[2]) * 19'sd10 + SUM_W'(w_dig[3]);

    assign w_limit = $signed({3'b000, i_limit});

    always_comb begin
        if (w_sum >= w_limit) begin
            o_torque = i_limit;
        end else if (w_sum < 0) begin
            o_torque = '0;
        end else begin
            o_torque = w_sum[15:0];
        end
    end

endmodule

// File: design/tcfp_out_buf.sv
// two-entry output register with skid stage for parser results
// depends on tcfp_pkg and assert_macros.svh
`include "assert_macros.svh"

module tcfp_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tcfp_pkg::t_result  i_result,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_taken,
    output tcfp_pkg::t_result  o_result
);

    logic              r_main_valid;
    logic              r_skid_valid;
    tcfp_pkg::t_result r_main;
    tcfp_pkg::t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || i_taken) begin
            if (r_skid_valid) begin
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
                if (i_push) begin
                    r_main <= i_result;
                end
            end
        end else if (i_push) begin
            r_skid       <= i_result;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;

    `TCFP_ASSERT(a_skid_needs_main, i_clk, i_rst_n, !r_skid_valid || r_main_valid, "skid full while main empty")
    `TCFP_ASSERT(a_no_push_when_full, i_clk, i_rst_n, !(i_push && r_skid_valid), "result pushed into full buffer")

endmodule

// File: bench/torque_frame_checker.sv
// scoreboard for the torque command frame parser: watches both streams and the limit writes,
// predicts one result per frame end and compares it field by field
// depends on tcfp_pkg
module torque_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [87:0] i_m_tdata,
    input  logic [4:0]  i_m_tuser,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]         rx_store [tcfp_pkg::MAX_LEN_DEF];
    logic [5:0]         stored_cnt;
    logic               cr_seen;
    logic [15:0]        left_now, right_now, left_old, right_old, limit_now;
    logic [7:0]         mode_now, mode_old, side_now;
    tcfp_pkg::t_result  frame_results_q [$];

    // weighted sum of four characters, clamped to 0..limit
    function automatic logic [15:0] torque_from_digits(input int pos);
        int sum;
        int w;
        sum = 0;
        w   = 1000;
        for (int i = 0; i < 4; i++) begin
            sum += (int'(rx_store[(pos + i) % tcfp_pkg::MAX_LEN_DEF])
                    - int'(tcfp_pkg::CH_ZERO)) * w;
            w   /= 10;
        end
        if (sum >= int'(limit_now)) return limit_now;
        if (sum < 0) return 16'd0;
        return sum[15:0];
    endfunction

    task automatic predict_byte(input logic [7:0] c);
        tcfp_pkg::t_result r;
        bit                emit;
        r    = '0;
        emit = 1'b0;
        if (cr_seen) begin
            cr_seen = 1'b0;
            emit    = 1'b1;
            if (c != tcfp_pkg::CH_LF) begin
                r.status = tcfp_pkg::ST_BAD_TERM;
            end else if (stored_cnt != tcfp_pkg::FRAME_LEN) begin
                r.status = tcfp_pkg::ST_BAD_LEN;
            end else begin
                r.status = tcfp_pkg::ST_OK;
                if (rx_store[0] == tcfp_pkg::CH_T && rx_store[1] == tcfp_pkg::CH_L) begin
                    left_old       = left_now;
                    left_now       = torque_from_digits(2);
                    r.left_updated = 1'b1;
                end
                if (rx_store[6] == tcfp_pkg::CH_T && rx_store[7] == tcfp_pkg::CH_R) begin
                    right_old       = right_now;
                    right_now       = torque_from_digits(8);
                    r.right_updated = 1'b1;
                end
                if (rx_store[12] == tcfp_pkg::CH_M) begin
                    mode_old       = mode_now;
                    mode_now       = rx_store[13] - tcfp_pkg::CH_ZERO;
                    side_now       = rx_store[14] - tcfp_pkg::CH_ZERO;
                    r.mode_updated = 1'b1;
                end
            end
            stored_cnt = '0;
        end else if (c == tcfp_pkg::CH_CR) begin
            cr_seen = 1'b1;
        end else if (stored_cnt < tcfp_pkg::MAX_LEN_DEF) begin
            rx_store[stored_cnt[4:0]] = c;
            stored_cnt                = stored_cnt + 6'd1;
        end else begin
            stored_cnt = '0;
            emit       = 1'b1;
            r.status   = tcfp_pkg::ST_OVERFLOW;
        end
        if (emit) begin
            r.left_torque         = left_now;
            r.right_torque        = right_now;
            r.left_torque_before  = left_old;
            r.right_torque_before = right_old;
            r.motion_mode         = mode_now;
            r.motion_mode_before  = mode_old;
            r.side_code           = side_now;
            frame_results_q.push_back(r);
        end
    endtask

    task automatic check_field(input string fname, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            o_fail_count++;
            $display("%0t ns: %s expected %0d actual %0d", $time, fname, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        tcfp_pkg::t_result want;
        if (!i_rst_n) begin
            stored_cnt = '0;
            cr_seen    = 1'b0;
            left_now   = '0;
            right_now  = '0;
            left_old   = '0;
            right_old  = '0;
            mode_now   = '0;
            mode_old   = '0;
            side_now   = '0;
            limit_now  = tcfp_pkg::TORQUE_LIMIT_RST;
            frame_results_q.delete();
        end else begin
            if (i_cfg_we) limit_now = i_cfg_wdata;
            if (i_m_tvalid && i_m_tready) begin
                if (frame_results_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t ns: result transaction with none expected, status %0d tdata %h",
                             $time, i_m_tuser[1:0], i_m_tdata);
                end else begin
                    want = frame_results_q.pop_front();
                    o_checked++;
                    check_field("status", want.status, i_m_tuser[1:0]);
                    check_field("left_updated", want.left_updated, i_m_tuser[2]);
                    check_field("right_updated", want.right_updated, i_m_tuser[3]);
                    check_field("mode_updated", want.mode_updated, i_m_tuser[4]);
                    check_field("left_torque", want.left_torque, i_m_tdata[15:0]);
                    check_field("right_torque", want.right_torque, i_m_tdata[31:16]);
                    check_field("left_torque_before", want.left_torque_before,
                                i_m_tdata[47:32]);
                    check_field("right_torque_before", want.right_torque_before,
                                i_m_tdata[63:48]);
                    check_field("motion_mode", want.motion_mode, i_m_tdata[71:64]);
                    check_field("motion_mode_before", want.motion_mode_before,
                                i_m_tdata[79:72]);
                    check_field("side_code", want.side_code, i_m_tdata[87:80]);
                end
            end
            if (i_s_tvalid && i_s_tready) predict_byte(i_s_tdata);
        end
        o_pending = frame_results_q.size();
    end

endmodule

// File: bench/torque_command_frame_parser_test.sv
// top of the torque command frame parser bench: clock, reset, byte stimulus, receiver stalls
// and the verdict; depends on tcfp_pkg, torque_command_frame_parser and torque_frame_checker
module torque_command_frame_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [87:0] o_m_tdata;
    logic [4:0]  o_m_tuser;

    int fail_count, pending, checked;
    int s_idle, m_idle, hold_len;
    int bytes_sent;
    logic [7:0] byte_q [$];

    torque_command_frame_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    torque_frame_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #2ms;
        $display("torque_command_frame_parser_test NOT OK");
        $finish;
    end

    // receiver: random stalls, or a counted hold-off once one is requested
    initial begin
        int hold_left;
        bit hold_done;
        hold_left  = 0;
        hold_done  = 1'b0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_len > 0 && !hold_done) begin
                hold_left = hold_len;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left--;
            end else begin
                i_m_tready <= ($urandom_range(99) >= m_idle);
            end
        end
    end

    function automatic logic [7:0] any_but_cr();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == tcfp_pkg::CH_CR);
        return b;
    endfunction

    function automatic logic [7:0] pick_tag(input logic [7:0] tag);
        return ($urandom_range(99) < 85) ? tag : any_but_cr();
    endfunction

    function automatic logic [7:0] digit_or_junk();
        return ($urandom_range(99) < 85) ? tcfp_pkg::CH_ZERO + 8'($urandom_range(9))
                                         : any_but_cr();
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < s_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic flush_bytes();
        while (byte_q.size() > 0) send_byte(byte_q.pop_front());
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic queue_torque_digits();
        int fk;
        fk = $urandom_range(9);
        for (int i = 0; i < 4; i++) begin
            case (fk)
                0:       byte_q.push_back(tcfp_pkg::CH_ZERO + 8'd9);
                1:       byte_q.push_back(tcfp_pkg::CH_ZERO);
                2:       byte_q.push_back(any_but_cr());
                default: byte_q.push_back(tcfp_pkg::CH_ZERO + 8'($urandom_range(9)));
            endcase
        end
    endtask

    // one random sequence: mostly proper frames, else framing faults, overflow and line noise
    task automatic queue_random_sequence();
        int kind;
        int len;
        kind = $urandom_range(99);
        if (kind < 55) begin
            byte_q.push_back(pick_tag(tcfp_pkg::CH_T));
            byte_q.push_back(pick_tag(tcfp_pkg::CH_L));
            queue_torque_digits();
            byte_q.push_back(pick_tag(tcfp_pkg::CH_T));
            byte_q.push_back(pick_tag(tcfp_pkg::CH_R));
            queue_torque_digits();
            byte_q.push_back(pick_tag(tcfp_pkg::CH_M));
            byte_q.push_back(digit_or_junk());
            byte_q.push_back(digit_or_junk());
            byte_q.push_back(tcfp_pkg::CH_CR);
            byte_q.push_back(tcfp_pkg::CH_LF);
        end else if (kind < 67) begin
            len = $urandom_range(32);
            repeat (len) byte_q.push_back(any_but_cr());
            byte_q.push_back(tcfp_pkg::CH_CR);
            byte_q.push_back(tcfp_pkg::CH_LF);
        end else if (kind < 77) begin
            len = $urandom_range(20);
            repeat (len) byte_q.push_back(any_but_cr());
            byte_q.push_back(tcfp_pkg::CH_CR);
            do byte_q.push_back(8'($urandom_range(255))); while (byte_q[$] == tcfp_pkg::CH_LF);
        end else if (kind < 85) begin
            repeat (tcfp_pkg::MAX_LEN_DEF + 1) byte_q.push_back(any_but_cr());
        end else begin
            len = $urandom_range(1, 4);
            repeat (len) byte_q.push_back(8'($urandom_range(255)));
        end
    endtask

    initial begin
        int seg_start;
        int wait_cnt;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        s_idle      = 22;
        m_idle      = 49;
        hold_len    = 0;
        bytes_sent  = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: clamp at the reset limit, negative sum, extreme bytes for mode and side
        byte_q = '{tcfp_pkg::CH_T, tcfp_pkg::CH_L, "9", "9", "9", "9",
                   tcfp_pkg::CH_T, tcfp_pkg::CH_R, "/", "0", "0", "0",
                   tcfp_pkg::CH_M, 8'hFF, 8'h00, tcfp_pkg::CH_CR, tcfp_pkg::CH_LF};
        // bad terminator, then an empty frame
        byte_q.push_back(tcfp_pkg::CH_CR);
        byte_q.push_back("A");
        byte_q.push_back(tcfp_pkg::CH_CR);
        byte_q.push_back(tcfp_pkg::CH_LF);
        flush_bytes();

        for (int seg = 0; seg < 6; seg++) begin
            s_idle = (seg < 2) ? 22 : (seg < 4) ? 49 : 0;
            m_idle = (seg < 2) ? 49 : (seg < 4) ? 22 : 0;
            case (seg)
                0:       write_limit(16'd0);
                1:       write_limit(16'd65535);
                2:       write_limit(16'd9999);
                3:       write_limit(16'($urandom_range(65535)));
                4:       write_limit(16'd1);
                default: write_limit(tcfp_pkg::TORQUE_LIMIT_RST);
            endcase
            seg_start = bytes_sent;
            if (seg == 0) begin
                // long receiver stall while bad terminators keep producing results
                hold_len = 150;
                repeat (12) begin
                    byte_q.push_back(tcfp_pkg::CH_CR);
                    byte_q.push_back("x");
                end
                flush_bytes();
            end
            while (bytes_sent - seg_start < 160) begin
                queue_random_sequence();
                flush_bytes();
            end
        end

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 20000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (4) @(posedge i_clk);

        $display("run covered %0d received bytes and %0d frame results under six torque limits",
                 bytes_sent, checked);
        $display("incl. clamping, framing faults, overflow and a long receiver stall");
        if (fail_count == 0 && pending == 0) begin
            $display("torque_command_frame_parser_test OK");
        end else begin
            $display("torque_command_frame_parser_test NOT OK");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/tcfp_pkg.sv
design/tcfp_cell.sv
design/tcfp_torque_dec.sv
design/tcfp_out_buf.sv
design/torque_command_frame_parser.sv
bench/torque_frame_checker.sv
bench/torque_command_frame_parser_test.sv
